// File: sv/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg: shared types, constants and arithmetic helpers
// Operation codes, register indexes, reset values and the front/back token.
// ----------------------------------------------------------------------------
package frs_pkg;

	localparam int FracBitsDef = 16;
	localparam int MaxElementsDef = 4096;
	localparam int DenomGuardDef = 1;

	typedef enum logic [1:0] {
		OP_ACC = 2'd0,
		OP_DECIDE = 2'd1,
		OP_UPDATE = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_STEP_MAX = 3'd0,
		REG_STEP_MIN = 3'd1,
		REG_GROW = 3'd2,
		REG_SHRINK = 3'd3,
		REG_DECAY = 3'd4,
		REG_DAMP_START = 3'd5,
		REG_GOOD_NEEDED = 3'd6,
		REG_FORCE_LIMIT = 3'd7
	} reg_idx_t;

	localparam logic [31:0] RstStepMax = 32'd1677722;
	localparam logic [31:0] RstStepMin = 32'd16777;
	localparam logic [31:0] RstGrow = 32'd1181116006;
	localparam logic [31:0] RstShrink = 32'd536870912;
	localparam logic [31:0] RstDecay = 32'd1063004406;
	localparam logic [30:0] RstDampStart = 31'd107374182;
	localparam logic [7:0] RstGoodNeeded = 8'd5;
	localparam logic [31:0] RstForceLimit = 32'd655360;
	localparam logic [31:0] OneQ30 = 32'h4000_0000;
	localparam logic [63:0] SumCap = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] step_max;
		logic [31:0] step_min;
		logic [31:0] grow_factor;
		logic [31:0] shrink_factor;
		logic [31:0] damping_decay;
		logic [30:0] damping_start;
		logic [7:0] good_steps_needed;
		logic [31:0] force_limit;
	} cfg_t;

	// classified word handed from the front to the back
	typedef struct packed {
		op_t op;
		logic [31:0] position;
		logic [31:0] velocity;
		logic [31:0] force_req;
		logic [31:0] inverse_mass;
	} tok_t;

	function automatic logic [31:0] satu32(input logic [63:0] x);
		satu32 = (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) sat32 = 32'sh7FFF_FFFF;
		else if (x < -64'sd2147483648) sat32 = 32'sh8000_0000;
		else sat32 = x[31:0];
	endfunction

endpackage

// File: sv/frs_if.sv
// ----------------------------------------------------------------------------
// frs_in_if / frs_out_if: valid/ready channels
// Input items and result items of the relaxation step unit.
// ----------------------------------------------------------------------------
interface frs_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic signed [31:0] force_req;
	logic [31:0] inverse_mass;
	modport source(output valid, op, position, velocity, force_req, inverse_mass,
		input ready);
	modport sink(input valid, op, position, velocity, force_req, inverse_mass,
		output ready);
endinterface

interface frs_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic signed [31:0] new_position;
	logic signed [31:0] new_velocity;
	logic [62:0] force_sq_sum;
	logic [31:0] effective_step;
	logic [31:0] step_count;
	logic [62:0] elapsed_time;
	modport source(output valid, kind, new_position, new_velocity, force_sq_sum,
		effective_step, step_count, elapsed_time, input ready);
	modport sink(input valid, kind, new_position, new_velocity, force_sq_sum,
		effective_step, step_count, elapsed_time, output ready);
endinterface

// File: sv/frs_front.sv
// ----------------------------------------------------------------------------
// frs_front: input stage and token queue
// Buffers classified input words in a short FIFO for the back end.
// ----------------------------------------------------------------------------
module frs_front import frs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tok_t in_tok,
	output logic tok_valid,
	input logic tok_pop,
	output tok_t tok
);
	localparam int Depth = 4;
	tok_t mem_q [Depth];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic push;

	assign in_ready = cnt_q != 3'(Depth);
	assign push = in_valid && in_ready;
	assign tok_valid = cnt_q != 3'd0;
	assign tok = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (tok_pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(tok_pop);
		end
	end
endmodule

// File: sv/frs_sqrt.sv
// ----------------------------------------------------------------------------
// frs_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module frs_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] x,
	output logic done,
	output logic [31:0] root
);
	logic [63:0] rem_q;
	logic [31:0] r_q;
	logic [5:0] i_q;
	logic busy_q;
	logic [65:0] trial;
	logic [65:0] rem_sh;
	logic [63:0] x_q;

	assign rem_sh = {rem_q, x_q[63:62]};
	assign trial = {32'd0, r_q, 2'b01};
	assign root = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
			r_q <= '0;
			rem_q <= '0;
			x_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= 6'd0;
				r_q <= '0;
				rem_q <= '0;
				x_q <= x;
			end else if (busy_q) begin
				// rem*4 + next two bits against 4r+1
				if (rem_sh >= trial) begin
					rem_q <= 64'(rem_sh - trial);
					r_q <= {r_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh[63:0];
					r_q <= {r_q[30:0], 1'b0};
				end
				x_q <= {x_q[61:0], 2'b00};
				i_q <= i_q + 6'd1;
				if (i_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// File: sv/frs_div.sv
// ----------------------------------------------------------------------------
// frs_div: iterative restoring divider
// 128/64 unsigned division, one quotient bit per cycle, saturating at 64 bits.
// ----------------------------------------------------------------------------
module frs_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [127:0] num,
	input logic [63:0] den,
	output logic done,
	output logic [63:0] quo
);
	logic [127:0] n_q;
	logic [64:0] rem_q;
	logic [127:0] q_q;
	logic [63:0] d_q;
	logic [7:0] i_q;
	logic busy_q;
	logic [64:0] sh;

	assign sh = {rem_q[63:0], n_q[127]};
	assign quo = (q_q[127:64] != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : q_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
			n_q <= '0;
			rem_q <= '0;
			q_q <= '0;
			d_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				n_q <= num;
				rem_q <= '0;
				q_q <= '0;
				d_q <= den;
			end else if (busy_q) begin
				if (sh >= {1'b0, d_q}) begin
					rem_q <= sh - {1'b0, d_q};
					q_q <= {q_q[126:0], 1'b1};
				end else begin
					rem_q <= sh;
					q_q <= {q_q[126:0], 1'b0};
				end
				n_q <= {n_q[126:0], 1'b0};
				i_q <= i_q + 8'd1;
				if (i_q == 8'd127) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// File: sv/frs_back.sv
// ----------------------------------------------------------------------------
// frs_back: execution sequencer
// Accumulates sums, handles restarts, runs the decide sequence on the shared divider
// and root unit, and computes element updates through a small multiply sequence.
// ----------------------------------------------------------------------------
module frs_back import frs_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef,
	parameter int DENOM_GUARD = DenomGuardDef
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic tok_valid,
	output logic tok_pop,
	input tok_t tok,
	frs_out_if.source res
);
	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_ACC2 = 11'b00000000010,
		S_RDIV = 11'b00000000100,
		S_RSQ = 11'b00000001000,
		S_MIX = 11'b00000010000,
		S_LSQ = 11'b00000100000,
		S_LDIV = 11'b00001000000,
		S_LSQ2 = 11'b00010000000,
		S_FIN = 11'b00100000000,
		S_UPD = 11'b01000000000,
		S_OUT = 11'b10000000000
	} st_t;

	st_t st_q;
	logic [63:0] sum_ff_q, sum_vv_q;
	logic signed [63:0] sum_vf_q;
	logic [31:0] step_q, damp_q, keep_q, mix_q, applied_q, steps_q;
	logic [15:0] good_q;
	logic zero_q;
	logic [63:0] time_q;
	logic [63:0] ff_s1;
	logic [2:0] upd_q;
	tok_t t_q;
	logic signed [63:0] pa_q, pb_q, pc_q;
	logic signed [63:0] v1_q, v2_q;

	logic div_start, div_done, sq_start, sq_done;
	logic [127:0] div_num;
	logic [63:0] div_den, div_quo, sq_x;
	logic [31:0] sq_root;

	frs_div u_div(.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo));
	frs_sqrt u_sqrt(.clk, .arst_n, .start(sq_start), .x(sq_x), .done(sq_done),
		.root(sq_root));

	logic [63:0] lim2;
	logic [63:0] dsafe;
	assign lim2 = {32'd0, cfg.force_limit} * {32'd0, cfg.force_limit};
	assign dsafe = ((ff_s1 + 64'(DENOM_GUARD)) == 64'd0) ? 64'd1 : ff_s1 + 64'(DENOM_GUARD);

	assign tok_pop = (st_q == S_IDLE) && tok_valid;
	assign res.valid = st_q == S_OUT;

	// ratio saturation check from ratio_q60
	logic ratio_sat;
	assign ratio_sat = (dsafe[63:60] == 4'd0) && (sum_vv_q >= {dsafe[59:0], 4'd0});

	logic signed [63:0] fv, fsq, vsq;
	logic [63:0] ffn, vvn;
	logic signed [64:0] vfn;
	always_comb begin
		fsq = $signed(t_q.force_req) * $signed(t_q.force_req);
		vsq = $signed(t_q.velocity) * $signed(t_q.velocity);
		fv = $signed(t_q.velocity) * $signed(t_q.force_req);
		ffn = (sum_ff_q > SumCap - fsq) ? SumCap : sum_ff_q + fsq;
		vvn = (sum_vv_q > SumCap - vsq) ? SumCap : sum_vv_q + vsq;
		vfn = 65'(sum_vf_q) + 65'(fv);
	end

	// decide arithmetic, each a single 32x32 product
	logic [63:0] shr_p, grw_p, dec_p, mix_p, app_p;
	logic [31:0] shr_s, grw_s;
	always_comb begin
		shr_p = ({32'd0, step_q} * {32'd0, cfg.shrink_factor}) >> 30;
		grw_p = ({32'd0, step_q} * {32'd0, cfg.grow_factor}) >> 30;
		dec_p = ({32'd0, damp_q} * {32'd0, cfg.damping_decay}) >> 30;
		mix_p = ({32'd0, damp_q} * {32'd0, sq_root}) >> 30;
		app_p = ({32'd0, step_q} * {32'd0, sq_root}) >> 30;
		shr_s = satu32(shr_p);
		grw_s = satu32(grw_p);
	end

	logic signed [63:0] ah, bh, al, bl, accv, kick, drift;
	logic signed [31:0] accs, v2s;
	always_comb begin
		ah = pa_q >>> 30;
		bh = pb_q >>> 30;
		al = pa_q - (ah <<< 30);
		bl = pb_q - (bh <<< 30);
		accs = sat32(pc_q >>> FRAC_BITS);
		accv = 64'(accs);
		kick = (accv * $signed({32'd0, applied_q})) >>> 24;
		v2s = sat32(v1_q + kick);
		// drift works from the registered kick result
		drift = (v2_q * $signed({32'd0, applied_q})) >>> 24;
	end

	logic [31:0] ratio_c;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			sum_ff_q <= '0; sum_vv_q <= '0; sum_vf_q <= '0;
			step_q <= RstStepMax; damp_q <= {1'b0, RstDampStart};
			keep_q <= OneQ30; mix_q <= '0; zero_q <= 1'b0;
			applied_q <= '0; steps_q <= '0; time_q <= '0; good_q <= '0;
			div_start <= 1'b0; sq_start <= 1'b0; upd_q <= '0;
			ratio_c <= '0;
			res.kind <= 1'b0;
			res.new_position <= '0; res.new_velocity <= '0;
			res.force_sq_sum <= '0; res.effective_step <= '0;
			res.step_count <= '0; res.elapsed_time <= '0;
		end else begin
			div_start <= 1'b0;
			sq_start <= 1'b0;
			case (st_q)
				S_IDLE: if (tok_valid) begin
					t_q <= tok;
					case (tok.op)
						OP_ACC: st_q <= S_ACC2;
						OP_RESTART: begin
							sum_ff_q <= '0; sum_vv_q <= '0; sum_vf_q <= '0;
							step_q <= cfg.step_max; damp_q <= {1'b0, cfg.damping_start};
							good_q <= '0; keep_q <= OneQ30; mix_q <= '0; zero_q <= 1'b0;
							applied_q <= '0; steps_q <= '0; time_q <= '0;
						end
						OP_DECIDE: begin
							ff_s1 <= sum_ff_q;
							st_q <= S_RDIV;
						end
						default: begin
							upd_q <= 3'd0;
							st_q <= S_UPD;
						end
					endcase
				end
				S_ACC2: begin
					sum_ff_q <= ffn;
					sum_vv_q <= vvn;
					if (vfn > 65'sh0_7FFF_FFFF_FFFF_FFFF) sum_vf_q <= 64'sh7FFF_FFFF_FFFF_FFFF;
					else if (vfn < -65'sh0_8000_0000_0000_0000)
						sum_vf_q <= 64'sh8000_0000_0000_0000;
					else sum_vf_q <= vfn[63:0];
					st_q <= S_IDLE;
				end
				S_RDIV: begin
					if (sum_vf_q < 0) begin
						step_q <= (shr_s > cfg.step_min) ? shr_s : cfg.step_min;
						damp_q <= {1'b0, cfg.damping_start};
						good_q <= '0; zero_q <= 1'b1; keep_q <= '0; mix_q <= '0;
						sq_x <= ff_s1;
						sq_start <= ff_s1 > lim2;
						st_q <= (ff_s1 > lim2) ? S_LSQ : S_FIN;
					end else if (!div_start && !upd_q[0]) begin
						div_num <= {sum_vv_q, 64'd0} >> 4;
						div_den <= dsafe;
						div_start <= 1'b1;
						upd_q[0] <= 1'b1;
					end else if (div_done) begin
						upd_q[0] <= 1'b0;
						sq_x <= ratio_sat ? 64'hFFFF_FFFF_FFFF_FFFF : div_quo;
						sq_start <= 1'b1;
						st_q <= S_RSQ;
					end
				end
				S_RSQ: if (sq_done) st_q <= S_MIX;
				S_MIX: begin
					mix_q <= satu32(mix_p);
					keep_q <= (damp_q >= OneQ30) ? 32'd0 : OneQ30 - damp_q;
					zero_q <= 1'b0;
					if (good_q > {8'd0, cfg.good_steps_needed}) begin
						step_q <= (grw_s < cfg.step_max) ? grw_s : cfg.step_max;
						damp_q <= satu32(dec_p);
					end
					if (good_q != 16'hFFFF) good_q <= good_q + 16'd1;
					if (ff_s1 > lim2) begin
						sq_x <= ff_s1;
						sq_start <= 1'b1;
						st_q <= S_LSQ;
					end else st_q <= S_FIN;
				end
				S_LSQ: if (sq_done) begin
					div_num <= {64'd0, cfg.force_limit, 30'd0, 2'd0} >> 2;
					div_den <= {32'd0, sq_root};
					div_start <= 1'b1;
					st_q <= S_LDIV;
				end
				S_LDIV: if (div_done) begin
					sq_x <= ((div_quo > {32'd0, OneQ30}) ? {32'd0, OneQ30} : div_quo) << 30;
					sq_start <= 1'b1;
					st_q <= S_LSQ2;
				end
				S_LSQ2: if (sq_done) begin
					applied_q <= app_p[31:0];
					ratio_c <= 32'd1;
					st_q <= S_FIN;
				end
				S_FIN: begin
					logic [31:0] ap;
					logic [63:0] tn;
					ap = (ratio_c == 32'd1) ? applied_q : step_q;
					tn = time_q + {32'd0, ap};
					ratio_c <= 32'd0;
					applied_q <= ap;
					steps_q <= steps_q + 32'd1;
					time_q <= (tn > SumCap) ? SumCap : tn;
					sum_ff_q <= '0; sum_vv_q <= '0; sum_vf_q <= '0;
					res.kind <= 1'b0;
					res.new_position <= '0; res.new_velocity <= '0;
					res.force_sq_sum <= ff_s1[62:0];
					res.effective_step <= ap;
					res.step_count <= steps_q + 32'd1;
					res.elapsed_time <= (tn > SumCap) ? SumCap[62:0] : tn[62:0];
					st_q <= S_OUT;
				end
				S_UPD: begin
					upd_q <= upd_q + 3'd1;
					case (upd_q)
						3'd0: begin
							pa_q <= $signed({32'd0, keep_q}) * 64'($signed(t_q.velocity));
							pb_q <= $signed({32'd0, mix_q}) * 64'($signed(t_q.force_req));
							pc_q <= 64'($signed(t_q.force_req)) *
								$signed({32'd0, t_q.inverse_mass});
						end
						3'd1: v1_q <= zero_q ? 64'sd0 : ah + bh + ((al + bl) >>> 30);
						3'd2: v2_q <= 64'(v2s);
						default: begin
							res.kind <= 1'b1;
							res.new_velocity <= v2_q[31:0];
							res.new_position <= sat32(64'($signed(t_q.position)) + drift);
							res.force_sq_sum <= '0; res.effective_step <= '0;
							res.step_count <= '0; res.elapsed_time <= '0;
							st_q <= S_OUT;
						end
					endcase
				end
				S_OUT: if (res.ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: sv/fire_relaxation_step_unit.sv
// ----------------------------------------------------------------------------
// fire_relaxation_step_unit: FIRE optimizer step engine
// Accumulate, decide, update and restart words in fixed point.
// ----------------------------------------------------------------------------
// Accumulate adds a word to the sums; restart resets them and the state; update
// runs a multiply sequence plus result handoff. Decide uses the bit-serial 128/64
// divider and root unit, with a further root, divide and root when the force norm
// is over the limit. The input FIFO (4 words) accepts while the back end works.
// Reset (arst_n low) restores registers and state to their reset values.
module fire_relaxation_step_unit import frs_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef,
	parameter int DENOM_GUARD = DenomGuardDef
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	frs_in_if.sink in_ch,
	frs_out_if.source out_ch
);
	cfg_t cfg_q;
	tok_t in_tok, tok;
	logic tok_valid, tok_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{RstStepMax, RstStepMin, RstGrow, RstShrink, RstDecay,
				RstDampStart, RstGoodNeeded, RstForceLimit};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_STEP_MAX: cfg_q.step_max <= cfg_data;
				REG_STEP_MIN: cfg_q.step_min <= cfg_data;
				REG_GROW: cfg_q.grow_factor <= cfg_data;
				REG_SHRINK: cfg_q.shrink_factor <= cfg_data;
				REG_DECAY: cfg_q.damping_decay <= cfg_data;
				REG_DAMP_START: cfg_q.damping_start <= cfg_data[30:0];
				REG_GOOD_NEEDED: cfg_q.good_steps_needed <= cfg_data[7:0];
				REG_FORCE_LIMIT: cfg_q.force_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_tok = '{op_t'(in_ch.op), in_ch.position, in_ch.velocity,
		in_ch.force_req, in_ch.inverse_mass};

	frs_front u_front(.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_tok, .tok_valid, .tok_pop, .tok);

	frs_back #(.FRAC_BITS(FRAC_BITS), .DENOM_GUARD(DENOM_GUARD)) u_back(.clk, .arst_n,
		.cfg(cfg_q), .tok_valid, .tok_pop, .tok, .res(out_ch));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.kind))
		else $error("result dropped while stalled");
	a_upd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind |-> out_ch.step_count == 32'd0)
		else $error("update word carries step count");
endmodule
